@@ hdl/gskf_pkg.sv @@
package gskf_pkg;

  localparam int NUM_GENERATIONS = 4;
  localparam int ENTRIES_PER_GEN = 64;

  localparam int KEY_W   = 64;
  localparam int LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(63);

  localparam int GEN_W     = (NUM_GENERATIONS > 1) ? $clog2(NUM_GENERATIONS) : 1;
  localparam int ENT_W     = $clog2(ENTRIES_PER_GEN);
  localparam int FILL_W    = $clog2(ENTRIES_PER_GEN + 1);
  localparam int CMP_W     = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
  localparam int ADDR_W    = GEN_W + ENT_W;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam int OUT_W     = 8;

  localparam logic [GEN_W-1:0]  LAST_GEN = GEN_W'(NUM_GENERATIONS - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ENTRIES_PER_GEN);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic rotated;
    logic filtered;
  } result_t;

endpackage

@@ hdl/generational_seen_key_filter.sv @@
// Generational seen-key admission filter.
// Request channel (s_tvalid/s_tready/s_tdata) carries a 64-bit key. Response
// channel (m_tvalid/m_tready/m_tdata) returns filtered in bit 0 (1 = key was
// unseen and is now recorded) and rotated in bit 1 (1 = the oldest generation
// was emptied and reused). Each request gives exactly one response, in order.
// The gen_limit register is to be written through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this. A request is accepted, then
// the search reads each stored key of each generation in turn; on a miss an
// insert step follows, and then the response is handed over. The key store
// has a single read port and there is one 64-bit comparator, so stored keys
// are compared one at a time; a hit ends the search early.
// The block takes one request at a time; s_tready is high only when idle.
// A finished response sits in the output register, so a new request is taken
// while the receiver stalls; the next response then waits for that register.
// Synchronous reset empties all generations, selects generation 0 and sets
// gen_limit to 63. The key store itself is not cleared.
module generational_seen_key_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gskf_pkg::KEY_W-1:0]        s_tdata,   // key
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gskf_pkg::OUT_W-1:0]        m_tdata,   // filtered, rotated, zero pad
  input  logic                              cfg_we,
  input  logic [gskf_pkg::LIMIT_W-1:0]      cfg_wdata  // gen_limit
);
  import gskf_pkg::*;

  logic [LIMIT_W-1:0] gen_limit;
  logic               start;
  logic               idle;
  logic [ADDR_W-1:0]  rd_addr;
  logic [KEY_W-1:0]   rd_data;
  ram_wr_t            wr;
  logic               res_valid;
  result_t            res;
  logic               res_take;

  assign s_tready = idle;
  assign start    = s_tvalid && s_tready;
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      gen_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_W'({res.rotated, res.filtered});
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  gskf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  gskf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .key       (s_tdata),
    .gen_limit (gen_limit),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

endmodule

@@ hdl/gskf_ram.sv @@
module gskf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/gskf_ctrl.sv @@
module gskf_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gskf_pkg::KEY_W-1:0]    key,
  input  logic [gskf_pkg::LIMIT_W-1:0]  gen_limit,
  output logic [gskf_pkg::ADDR_W-1:0]   rd_addr,
  input  logic [gskf_pkg::KEY_W-1:0]    rd_data,
  output gskf_pkg::ram_wr_t             wr,
  output logic                          idle,
  output logic                          res_valid,
  output gskf_pkg::result_t             res,
  input  logic                          res_take
);
  import gskf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t            state;
  logic [KEY_W-1:0]  key_reg;
  logic [GEN_W-1:0]  g_idx;
  logic [FILL_W-1:0] e_idx;
  logic              cmp_vld;
  logic [FILL_W-1:0] gen_fill [NUM_GENERATIONS];
  logic [GEN_W-1:0]  current_gen;

  logic [GEN_W-1:0]  fill_idx;
  logic [FILL_W-1:0] fill_sel;
  logic              hit_now;
  logic              rd_issue;
  logic              rot;
  logic [GEN_W-1:0]  nxt_gen;
  logic [FILL_W-1:0] base;

  // One fill-count read port: the scanned generation while searching,
  // the generation taking inserts otherwise.
  assign fill_idx = (state == ST_SCAN) ? g_idx : current_gen;
  assign fill_sel = gen_fill[fill_idx];

  // The single comparator checks the entry read in the previous cycle.
  assign hit_now  = cmp_vld && (rd_data == key_reg);
  assign rd_issue = (state == ST_SCAN) && !hit_now && (e_idx < fill_sel);
  assign rd_addr  = {g_idx, e_idx[ENT_W-1:0]};

  assign rot     = (CMP_W'(fill_sel) > CMP_W'(gen_limit)) || (fill_sel >= FULL_FILL);
  assign nxt_gen = !rot ? current_gen :
                   (current_gen == LAST_GEN) ? '0 : current_gen + 1'b1;
  assign base    = rot ? '0 : fill_sel;

  always_comb begin
    wr.en   = (state == ST_INSERT) && !hit_now;
    wr.addr = {nxt_gen, base[ENT_W-1:0]};
    wr.data = key_reg;
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_RESULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cmp_vld     <= 1'b0;
      current_gen <= '0;
      for (int i = 0; i < NUM_GENERATIONS; i++) begin
        gen_fill[i] <= '0;
      end
    end else begin
      cmp_vld <= rd_issue;
      case (state)
        ST_IDLE: begin
          if (start) begin
            key_reg <= key;
            g_idx   <= '0;
            e_idx   <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit_now) begin
            res.filtered <= 1'b0;
            res.rotated  <= 1'b0;
            state        <= ST_RESULT;
          end else if (rd_issue) begin
            e_idx <= e_idx + 1'b1;
          end else if (g_idx == LAST_GEN) begin
            state <= ST_INSERT;
          end else begin
            g_idx <= g_idx + 1'b1;
            e_idx <= '0;
          end
        end
        ST_INSERT: begin
          if (hit_now) begin
            res.filtered <= 1'b0;
            res.rotated  <= 1'b0;
          end else begin
            res.filtered      <= 1'b1;
            res.rotated       <= rot;
            current_gen       <= nxt_gen;
            gen_fill[nxt_gen] <= base + 1'b1;
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    gen_fill[current_gen] <= FULL_FILL)
    else $error("fill count of the current generation exceeds its size");

  a_write_filters: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> (state == ST_RESULT) && res.filtered)
    else $error("a store write did not produce a filter result");

  a_rotate_implies_filter: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT) && res.rotated |-> res.filtered)
    else $error("rotation reported on a pass result");

  a_start_scans: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && start |=> (state == ST_SCAN))
    else $error("accepted request did not start a scan");

endmodule

@@ tb/tb_generational_seen_key_filter.sv @@
`timescale 1ns / 100ps

module tb_generational_seen_key_filter;
  import gskf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned HISTORY_MAX = 400;
  localparam int unsigned TAIL_CYCLES = 300;

  typedef struct {
    bit                 is_cfg;
    logic [KEY_W-1:0]   key;
    logic [LIMIT_W-1:0] limit;
    bit                 typed;
    result_t            verdict;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [KEY_W-1:0]   s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  // Shadow copy of the generation sets.
  logic [KEY_W-1:0]   seen_keys [NUM_GENERATIONS][ENTRIES_PER_GEN];
  int unsigned        gen_count [NUM_GENERATIONS];
  int unsigned        active_gen = 0;
  logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;

  result_t            expected_verdicts [$];
  logic [KEY_W-1:0]   recent_keys [$];
  bit                 steady = 1'b0;
  int unsigned        fails = 0;
  int unsigned        requests = 0;
  int unsigned        hits = 0;
  int unsigned        misses = 0;
  int unsigned        rotations = 0;
  int unsigned        cycles = 0;

  stim_row_t directed [] = '{
    '{0, 64'h0, 0, 1, '{rotated: 1'b0, filtered: 1'b1}},
    '{0, 64'h0, 0, 1, '{rotated: 1'b0, filtered: 1'b0}},
    '{0, '1, 0, 1, '{rotated: 1'b0, filtered: 1'b1}},
    '{0, '1, 0, 1, '{rotated: 1'b0, filtered: 1'b0}},
    '{0, 64'h1, 0, 1, '{rotated: 1'b0, filtered: 1'b1}},
    '{0, 64'h8000_0000_0000_0000, 0, 1, '{rotated: 1'b0, filtered: 1'b1}},
    '{0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, '0},
    '{0, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, '0},
    '{0, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, '0},
    '{0, 64'h5555_5555_5555_5555, 0, 0, '0},
    '{0, 64'h1, 0, 0, '0},
    // Lowering the limit below the current fill rotates on the next miss.
    '{1, 64'h0, 6'd0, 0, '0},
    '{0, 64'h0123_4567_89AB_CDEF, 0, 0, '0},
    '{0, 64'hFEDC_BA98_7654_3210, 0, 0, '0},
    '{0, 64'h0, 0, 0, '0},
    '{0, 64'h2, 0, 0, '0},
    '{0, 64'h3, 0, 0, '0},
    // Generation 0 has wrapped around and been emptied by now.
    '{0, 64'h0, 0, 0, '0},
    '{0, '1, 0, 0, '0},
    '{1, 64'h0, 6'd63, 0, '0},
    '{0, 64'h4, 0, 0, '0},
    '{0, 64'h8000_0000_0000_0000, 0, 0, '0}
  };

  // A limit of -1 picks a random value for that phase.
  int          phase_limit [6] = '{0, 1, 3, -1, 7, 63};
  int unsigned phase_items [6] = '{150, 150, 200, 200, 150, 500};

  generational_seen_key_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t admit_key(input logic [KEY_W-1:0] k);
    result_t     r;
    int unsigned slot;
    r = '0;
    for (int g = 0; g < NUM_GENERATIONS; g++) begin
      for (int e = 0; e < gen_count[g]; e++) begin
        if (seen_keys[g][e] == k) begin
          return r;
        end
      end
    end
    slot = active_gen;
    if (gen_count[slot] > limit_shadow || gen_count[slot] >= ENTRIES_PER_GEN) begin
      slot = (slot + 1) % NUM_GENERATIONS;
      gen_count[slot] = 0;
      r.rotated = 1'b1;
    end
    active_gen = slot;
    seen_keys[slot][gen_count[slot]] = k;
    gen_count[slot]++;
    r.filtered = 1'b1;
    return r;
  endfunction

  // Offers one request and returns at the edge that accepts it; valid stays
  // high until the next falling edge decides what comes next.
  task automatic send_key(input logic [KEY_W-1:0] k, input bit typed, input result_t verdict);
    result_t predicted;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    do @(posedge clk); while (!s_tready);
    predicted = admit_key(k);
    expected_verdicts.push_back(typed ? verdict : predicted);
    recent_keys.push_back(k);
    if (recent_keys.size() > HISTORY_MAX) begin
      void'(recent_keys.pop_front());
    end
    requests++;
  endtask

  task automatic wait_all_verdicts();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    wait_all_verdicts();
    @(negedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    limit_shadow = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[1:0]);
      if (got.filtered) begin
        misses++;
      end else begin
        hits++;
      end
      if (got.rotated) begin
        rotations++;
      end
      if (expected_verdicts.size() == 0) begin
        $error("response with no request outstanding: m_tdata=%0h", m_tdata);
        fails++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got.filtered !== want.filtered) begin
          $error("filtered: expected %0b, got %0b", want.filtered, got.filtered);
          fails++;
        end
        if (got.rotated !== want.rotated) begin
          $error("rotated: expected %0b, got %0b", want.rotated, got.rotated);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_generational_seen_key_filter: FAIL");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0]   k;
    logic [LIMIT_W-1:0] lim;
    int unsigned        r;
    int unsigned        span;
    foreach (gen_count[g]) gen_count[g] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_limit(directed[i].limit);
      end else begin
        send_key(directed[i].key, directed[i].typed, directed[i].verdict);
      end
    end

    // Mostly fresh keys and repeats of recent ones, so hits, misses and
    // evictions all occur; a few small and extreme keys are mixed in.
    for (int ph = 0; ph < 6; ph++) begin
      lim = (phase_limit[ph] < 0) ? LIMIT_W'($urandom_range(63)) : LIMIT_W'(phase_limit[ph]);
      set_limit(lim);
      for (int n = 0; n < phase_items[ph]; n++) begin
        steady = (ph == 2 && n < 150);
        r = $urandom_range(99);
        if (r < 45 || recent_keys.size() == 0) begin
          k = {$urandom, $urandom};
        end else if (r < 85) begin
          span = $urandom_range(1, recent_keys.size());
          k = recent_keys[recent_keys.size() - $urandom_range(1, span)];
        end else if (r < 95) begin
          k = KEY_W'($urandom_range(15));
        end else begin
          case ($urandom_range(2))
            0: k = '0;
            1: k = '1;
            default: k = KEY_W'(1) << $urandom_range(KEY_W - 1);
          endcase
        end
        send_key(k, 1'b0, '0);
      end
      steady = 1'b0;
    end

    wait_all_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests over 8 limit settings: %0d seen, %0d new, %0d rotations.",
             requests, hits, misses, rotations);
    $display("Mismatches or stray responses: %0d.", fails);
    if (fails == 0) begin
      $display("tb_generational_seen_key_filter: PASS");
    end else begin
      $display("tb_generational_seen_key_filter: FAIL");
    end
    $finish;
  end

endmodule

@@ generational_seen_key_filter.f @@
hdl/gskf_pkg.sv
hdl/gskf_ram.sv
hdl/gskf_ctrl.sv
hdl/generational_seen_key_filter.sv
tb/tb_generational_seen_key_filter.sv
